// File: sv/nta_pkg.sv
package nta_pkg;

  // Format selector codes carried in the kind field
  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  // Binary and BCD sizes
  localparam int VALUE_W  = 32;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int STEP_W   = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  // Fixed characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [15:0][7:0] HEX_DIGITS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
  } nta_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } nta_rsp_t;

  // Status of the BCD converter as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } nta_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

endpackage

// File: sv/number_to_ascii_formatter_core.sv
// Hex items go from accept straight to the character steps; decimal items first
// pass through the shift-add-3 BCD converter, which shifts in all 32 value bits,
// then its digits are loaded. Throughput: one character per cycle once started
// while rsp_ready allows; the next item is taken after the last word is loaded.
// Reset (rst, synchronous, active high) returns the sequencer to idle and empties
// the output register; no other state is kept between items.
module number_to_ascii_formatter_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  nta_pkg::nta_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output nta_pkg::nta_rsp_t rsp
);
  import nta_pkg::*;

  nta_state_t         state;
  nta_state_t         state_next;
  logic [BCD_W-1:0]   work;
  logic [3:0]         idx;
  logic [1:0]         pre;
  logic               hex_mode;
  logic               conv_start;
  logic               load;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  bcd_stat_t          conv_stat;
  logic [3:0]         msd;
  logic [7:0]         char_val;
  logic               char_last;

  // Magnitude for the converter
  always_comb begin
    if (req.kind == KIND_SDEC && req.value[VALUE_W-1]) begin
      mag = '0 - req.value;
    end else begin
      mag = req.value;
    end
  end

  nta_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .bin   (mag),
    .stat  (conv_stat),
    .bcd   (bcd)
  );

  // Locate the most significant nonzero digit
  always_comb begin
    msd = 4'd0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        msd = 4'(i);
      end
    end
  end

  // Select the current character
  always_comb begin
    if (pre == 2'd2) begin
      char_val = CH_ZERO;
    end else if (pre == 2'd1) begin
      char_val = hex_mode ? CH_X : CH_MINUS;
    end else begin
      char_val = hex_char(work[{idx, 2'b00} +: 4]);
    end
    char_last = (pre == 2'd0) && (idx == 4'd0);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == KIND_HEX) begin
            state_next = ST_EMIT;
          end else if (req.kind inside {KIND_UDEC, KIND_SDEC}) begin
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load && char_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready  = 1'b0;
    conv_start = 1'b0;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        conv_start = req_valid && (req.kind inside {KIND_UDEC, KIND_SDEC});
      end
      ST_EMIT: begin
        load = !rsp_valid || rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item, then the digits, then step through the text
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      hex_mode <= (req.kind == KIND_HEX);
      if (req.kind == KIND_HEX) begin
        work <= {{(BCD_W-VALUE_W){1'b0}}, req.value};
        idx  <= 4'd7;
        pre  <= 2'd2;
      end else begin
        pre  <= {1'b0, (req.kind == KIND_SDEC) && req.value[VALUE_W-1]};
      end
    end else if (state == ST_CONV && conv_stat.done) begin
      work <= bcd;
      idx  <= msd;
    end else if (load && !char_last) begin
      if (pre != 2'd0) begin
        pre <= pre - 2'd1;
      end else begin
        idx <= idx - 4'd1;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.character <= char_val;
      rsp.last      <= char_last;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    conv_start |-> !conv_stat.busy)
    else $error("converter started while busy");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_stat.done |-> state == ST_CONV)
    else $error("converter done outside conversion state");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> idx <= 4'd9)
    else $error("digit index out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load && char_last |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after last word");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !conv_stat.busy)
    else $error("ready while converter busy");
`endif

endmodule

// File: sv/nta_bcd_conv.sv
module nta_bcd_conv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nta_pkg::VALUE_W-1:0]  bin,
  output nta_pkg::bcd_stat_t           stat,
  output logic [nta_pkg::BCD_W-1:0]    bcd
);
  import nta_pkg::*;

  logic [VALUE_W-1:0] shreg;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;
  logic [BCD_W-1:0]   adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Control: one binary bit shifted in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load, then shift binary into the BCD digits
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= bin;
      bcd   <= '0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_W-1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: verif/tb_number_to_ascii_formatter_core.sv
`timescale 1ns / 1ps

module tb_number_to_ascii_formatter_core;
  import nta_pkg::*;

  // Selector value with no format behind it; the block drops such words
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam string HEX_SET = "0123456789ABCDEF";
  localparam int LONG_HOLD = 400;
  localparam int MAX_GAP = 100;
  localparam int DRAIN_CYCLES = 64;
  localparam int WORDS_PER_PHASE = 48;
  localparam int TIMEOUT_NS = 20_000_000;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  nta_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  nta_rsp_t rsp;

  // Expected characters in output order, and the failure count
  nta_rsp_t expected_chars[$];
  int fail_count = 0;

  // Traffic shaping
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Directed stimulus table
  nta_req_t row_word[$];
  string row_text[$];
  bit row_typed[$];

  number_to_ascii_formatter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Build the text the block should print for one word
  function automatic string format_text(input nta_req_t w);
    string s;
    int pos;
    logic [31:0] mag;
    s = "";
    mag = w.value;
    case (w.kind)
      KIND_UDEC, KIND_SDEC: begin
        if (w.kind == KIND_SDEC && w.value[31]) begin
          s = $sformatf("%c", CH_MINUS);
          mag = 32'd0 - w.value;
        end
        pos = s.len();
        if (mag == 32'd0) begin
          s = {s, $sformatf("%c", CH_ZERO)};
        end
        while (mag != 32'd0) begin
          s = {s.substr(0, pos - 1), $sformatf("%c", CH_ZERO + 8'(mag % 32'd10)),
               s.substr(pos, s.len() - 1)};
          mag = mag / 32'd10;
        end
      end
      KIND_HEX: begin
        s = $sformatf("%c%c", CH_ZERO, CH_X);
        for (int sh = 28; sh >= 0; sh -= 4) begin
          s = {s, $sformatf("%c", HEX_SET[w.value[sh +: 4]])};
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // Queue one run of characters, marking the final one
  function automatic void queue_text(input string s);
    nta_rsp_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.character = s[i];
      c.last = (i == s.len() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [31:0] value,
                                  input bit typed, input string text);
    nta_req_t w;
    w.kind = kind;
    w.value = value;
    row_word.push_back(w);
    row_typed.push_back(typed);
    row_text.push_back(text);
  endfunction

  // Mix full-range values with short numbers, decade edges and the sign edge
  function automatic nta_req_t random_word();
    nta_req_t w;
    logic [31:0] p;
    if ($urandom_range(99) < 6) begin
      w.kind = KIND_UNUSED;
    end else begin
      w.kind = 2'($urandom_range(2));
    end
    case ($urandom_range(4))
      1: w.value = $urandom_range(999);
      2: begin
        p = 32'd1;
        repeat ($urandom_range(9)) p = p * 32'd10;
        w.value = p + 32'($urandom_range(2)) - 32'd1;
        if ($urandom_range(1) == 1) begin
          w.value = 32'd0 - w.value;
        end
      end
      3: w.value = 32'h8000_0000 + 32'($urandom_range(16)) - 32'd8;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input nta_req_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drive the receiver: a requested long hold first, else random stalls
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= LONG_HOLD;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each accepted word against the oldest expected character
  always @(posedge clk) begin : check_rsp
    nta_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected word", rsp.character, 8'h00);
      end else begin
        want = expected_chars.pop_front();
        if (rsp.character !== want.character) begin
          report_mismatch("character", rsp.character, want.character);
        end
        if (rsp.last !== want.last) begin
          report_mismatch("last", 8'(rsp.last), 8'(want.last));
        end
      end
    end
  end

  initial begin : stimulus
    nta_req_t w;
    int sent;

    // Extremes with their text spelled out; the rest goes through the predictor
    add_row(KIND_UDEC,   32'h0000_0000, 1, "0");
    add_row(KIND_UDEC,   32'hFFFF_FFFF, 1, "4294967295");
    add_row(KIND_SDEC,   32'h8000_0000, 1, "-2147483648");
    add_row(KIND_SDEC,   32'h7FFF_FFFF, 1, "2147483647");
    add_row(KIND_SDEC,   32'hFFFF_FFFF, 1, "-1");
    add_row(KIND_SDEC,   32'h0000_0000, 1, "0");
    add_row(KIND_HEX,    32'h0000_0000, 1, "0x00000000");
    add_row(KIND_HEX,    32'hFFFF_FFFF, 1, "0xFFFFFFFF");
    add_row(KIND_UNUSED, 32'hFFFF_FFFF, 1, "");
    add_row(KIND_UNUSED, 32'h0000_0000, 1, "");
    add_row(KIND_UDEC,   32'd9,         0, "");
    add_row(KIND_UDEC,   32'd10,        0, "");
    add_row(KIND_UDEC,   32'd999999999, 0, "");
    add_row(KIND_UDEC,   32'd1000000000, 0, "");
    add_row(KIND_UDEC,   32'h7FFF_FFFF, 0, "");
    add_row(KIND_UDEC,   32'h8000_0000, 0, "");
    add_row(KIND_SDEC,   32'd1,         0, "");
    add_row(KIND_SDEC,   32'd9,         0, "");
    add_row(KIND_SDEC,   32'd10,        0, "");
    add_row(KIND_SDEC,   32'h8000_0001, 0, "");
    add_row(KIND_SDEC,   32'hFFFF_FFF6, 0, "");
    add_row(KIND_SDEC,   32'hC465_3600, 0, "");
    add_row(KIND_HEX,    32'h0123_4567, 0, "");
    add_row(KIND_HEX,    32'h89AB_CDEF, 0, "");

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < row_word.size(); i++) begin
      send_word(row_word[i]);
      queue_text(row_typed[i] ? row_text[i] : format_text(row_word[i]));
    end

    // Random words: free flow, idle sender, stalling receiver, both, long hold
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 87; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 87; end
        3: begin send_idle_pct = 28; recv_stall_pct <= 28; end
        4: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          hold_asked <= hold_asked + 1;
        end
        default: begin send_idle_pct = 0; recv_stall_pct <= 0; end
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        w = random_word();
        send_word(w);
        queue_text(format_text(w));
        if (w.kind != KIND_UNUSED) sent++;
      end
    end
    req_valid <= 1'b0;

    // Drain, then give the block time to show any stray word
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/nta_pkg.sv
sv/nta_bcd_conv.sv
sv/number_to_ascii_formatter_core.sv
verif/tb_number_to_ascii_formatter_core.sv
